// ----- src/shs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_HOMINGS_DEF   = 3;

  localparam int FIELD_BITS   = 16;
  localparam int COUNT_BITS   = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 2;
  localparam int IN_DATA_W    = 24;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_STEP = 2'd1,
    MODE_POLL = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_FIRST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SECOND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_THIRD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_FOURTH = 3'd4;

  typedef logic [3:0][1:0] coil_map_t;

  typedef struct packed {
    logic      forward;
    coil_map_t map;
  } coil_cfg_t;

  localparam coil_cfg_t COIL_CFG_RESET = '{forward: 1'b1,
                                           map: {2'd3, 2'd2, 2'd1, 2'd0}};

  function automatic logic [3:0] phase_pattern(input logic [1:0] idx);
    logic [3:0] pat;
    unique case (idx)
      2'd0: pat = 4'h5;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'hA;
      2'd3: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ----- src/shs_coil_drive.sv -----
`timescale 1ns / 1ps
`default_nettype none
module shs_coil_drive (
  input  wire shs_pkg::coil_cfg_t cfg,
  input  wire logic [1:0]         phase_idx,
  input  wire logic               enable,
  output logic [3:0]              coils
);

  logic [1:0] idx;
  logic [3:0] logical;

  always_comb begin
    idx = cfg.forward ? phase_idx : (2'd3 - phase_idx);
    logical = shs_pkg::phase_pattern(idx);
    coils = 4'h0;
    // later logical bits win on duplicate pins
    for (int i = 0; i < 4; i++) begin
      coils[cfg.map[i]] = logical[i];
    end
    if (!enable) begin
      coils = 4'h0;
    end
  end

endmodule
`default_nettype wire

// ----- src/stepper_homing_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// stepper homing sequencer
// in channel: one beat per command; in_tuser carries the mode (set target,
// step tick, poll hall), in_tdata the target and the sampled hall level
// out channel: exactly one result beat per input beat, in order, holding
// coil drive, at-target, home, hall flag, position and steps per rotation
// cfg port: single-cycle writes of direction and the four coil pin maps,
// done only while no beat is in flight; the user, not the block, ensures it
// output: a result is registered and appears in the cycle after its input beat is taken
// throughput: one beat per cycle unless out_tready holds the result; all
// state updates for a beat are done in one pass of compare, increment and
// subtract logic into the state and result registers
// stall: the result register holds while out_tready is low; in_tready
// stays high as long as the pending result leaves in the same cycle
// reset: rst_n low clears position, target, counters and hall flag, arms
// homing, restores forward direction and identity pin map, drops out_tvalid
module stepper_homing_sequencer #(
  parameter int POSITION_BITS = shs_pkg::POSITION_BITS_DEF,
  parameter int MAX_HOMINGS   = shs_pkg::MAX_HOMINGS_DEF
) (
  input  wire  logic                               clk,
  input  wire  logic                               rst_n,
  input  wire  logic                               in_tvalid,
  output logic                                     in_tready,
  // target [15:0], hall_level [16], zero fill
  input  wire  logic [shs_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode [1:0]
  input  wire  logic [shs_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire  logic                               out_tready,
  // coils [3:0], at_target [4], home [5], hall_seen [6], position [22:7],
  // rotation_steps [38:23], zero fill
  output logic [shs_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire  logic                               cfg_we,
  input  wire  logic [shs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  logic [shs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PW = POSITION_BITS;
  localparam int FW = shs_pkg::FIELD_BITS;
  localparam int CW = shs_pkg::COUNT_BITS;

  shs_pkg::coil_cfg_t cfg_r;

  logic [PW-1:0] target_r, target_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] since_r, since_nxt;
  logic [PW-1:0] lap_r, lap_nxt;
  logic          hall_r, hall_nxt;
  logic          armed_r, armed_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                            out_valid_r;
  logic [shs_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  shs_pkg::mode_t mode;
  logic [FW-1:0]  tgt_in;
  logic           level;
  logic [PW-1:0]  tgt_w;
  logic [PW+FW-1:0] tgt_ext;
  logic [PW+FW-1:0] pos_ext, lap_ext;
  logic           do_hall;
  logic           coil_en;
  logic [CW:0]    count_inc;
  logic [3:0]     coils;
  logic           accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign mode    = shs_pkg::mode_t'(in_tuser[1:0]);
  assign tgt_in  = in_tdata[FW-1:0];
  assign level   = in_tdata[FW];
  assign tgt_ext = {{PW{1'b0}}, tgt_in};
  assign tgt_w   = tgt_ext[PW-1:0];

  always_comb begin
    target_nxt = target_r;
    pos_nxt    = pos_r;
    since_nxt  = since_r;
    lap_nxt    = lap_r;
    hall_nxt   = hall_r;
    armed_nxt  = armed_r;
    count_nxt  = count_r;
    do_hall    = 1'b0;
    coil_en    = 1'b0;
    count_inc  = {1'b0, count_r} + 1'b1;
    unique case (mode)
      shs_pkg::MODE_SET: begin
        target_nxt = tgt_w;
        count_nxt  = '0;
      end
      shs_pkg::MODE_STEP: begin
        if (target_r != pos_r) begin
          pos_nxt   = pos_r + 1'b1;
          since_nxt = since_r + 1'b1;
          do_hall   = 1'b1;
          coil_en   = 1'b1;
        end
      end
      shs_pkg::MODE_POLL: begin
        do_hall = 1'b1;
      end
      shs_pkg::MODE_NONE: begin
      end
      default: begin
      end
    endcase
    if (do_hall) begin
      if (level) begin
        armed_nxt = 1'b1;
        hall_nxt  = 1'b0;
      end else if (armed_r) begin
        if (target_nxt >= pos_nxt) begin
          target_nxt = target_nxt - pos_nxt;
        end
        hall_nxt  = 1'b1;
        pos_nxt   = '0;
        armed_nxt = 1'b0;
        lap_nxt   = since_nxt;
        since_nxt = '0;
        if (count_inc > (CW + 1)'(MAX_HOMINGS)) begin
          target_nxt = '0;
          count_nxt  = '0;
        end else begin
          count_nxt = count_inc[CW-1:0];
        end
      end
    end
  end

  shs_coil_drive u_coil (
    .cfg       (cfg_r),
    .phase_idx (pos_nxt[1:0]),
    .enable    (coil_en),
    .coils     (coils)
  );

  assign pos_ext = {{FW{1'b0}}, pos_nxt};
  assign lap_ext = {{FW{1'b0}}, lap_nxt};

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[3:0]   = coils;
    out_data_nxt[4]     = (target_nxt == pos_nxt);
    out_data_nxt[5]     = (target_nxt == '0) && hall_nxt;
    out_data_nxt[6]     = hall_nxt;
    out_data_nxt[22:7]  = pos_ext[FW-1:0];
    out_data_nxt[38:23] = lap_ext[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      pos_r       <= '0;
      since_r     <= '0;
      lap_r       <= '0;
      hall_r      <= 1'b0;
      armed_r     <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        target_r <= target_nxt;
        pos_r    <= pos_nxt;
        since_r  <= since_nxt;
        lap_r    <= lap_nxt;
        hall_r   <= hall_nxt;
        armed_r  <= armed_nxt;
        count_r  <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= shs_pkg::COIL_CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shs_pkg::CFG_FORWARD:    cfg_r.forward <= cfg_wdata[0];
        shs_pkg::CFG_MAP_FIRST:  cfg_r.map[0]  <= cfg_wdata[1:0];
        shs_pkg::CFG_MAP_SECOND: cfg_r.map[1]  <= cfg_wdata[1:0];
        shs_pkg::CFG_MAP_THIRD:  cfg_r.map[2]  <= cfg_wdata[1:0];
        shs_pkg::CFG_MAP_FOURTH: cfg_r.map[3]  <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid_r)
    else $error("result valid right after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_at_target_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[4] == (target_r == pos_r)))
    else $error("at_target disagrees with state");

  a_hall_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    hall_r |-> !armed_r)
    else $error("hall flag set while homing armed");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [3:0] STEP_PHASES [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  typedef struct packed {
    logic        spare;
    logic [15:0] rotation_steps;
    logic [15:0] position;
    logic        hall_seen;
    logic        home;
    logic        at_target;
    logic [3:0]  coils;
  } coil_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [shs_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [shs_pkg::IN_USER_W-1:0] in_tuser = shs_pkg::MODE_POLL;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [shs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [shs_pkg::CFG_INDEX_W-1:0] cfg_index = shs_pkg::CFG_FORWARD;
  logic [shs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  stepper_homing_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stepper state as predicted
  logic [15:0] goal_pos;
  logic [15:0] cur_pos;
  logic [15:0] steps_since_home;
  logic [15:0] lap_count;
  logic        hall_active;
  logic        homing_armed;
  logic [2:0]  homing_count;
  logic        dir_forward;
  logic [1:0]  pin_map [4];

  coil_beat_t pending_beats [$];
  coil_beat_t got_beat;
  coil_beat_t want_beat;
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int magnet_left = 0;
  int stall_sel = 0;
  int stall_phase = 0;

  function automatic void reset_stepper();
    goal_pos = '0;
    cur_pos = '0;
    steps_since_home = '0;
    lap_count = '0;
    hall_active = 1'b0;
    homing_armed = 1'b1;
    homing_count = '0;
    dir_forward = shs_pkg::COIL_CFG_RESET.forward;
    for (int i = 0; i < 4; i++) pin_map[i] = shs_pkg::COIL_CFG_RESET.map[i];
  endfunction

  function automatic void sense_hall(logic level);
    logic [3:0] next_count;
    if (level) begin
      homing_armed = 1'b1;
      hall_active = 1'b0;
    end else if (homing_armed) begin
      if (goal_pos >= cur_pos) goal_pos = goal_pos - cur_pos;
      hall_active = 1'b1;
      cur_pos = '0;
      homing_armed = 1'b0;
      lap_count = steps_since_home;
      steps_since_home = '0;
      next_count = {1'b0, homing_count} + 4'd1;
      if (next_count > shs_pkg::MAX_HOMINGS_DEF) begin
        goal_pos = '0;
        homing_count = '0;
      end else begin
        homing_count = next_count[2:0];
      end
    end
  endfunction

  function automatic logic [3:0] drive_pattern(logic [15:0] pos);
    logic [1:0] idx;
    logic [3:0] logical;
    logic [3:0] drive;
    idx = dir_forward ? pos[1:0] : 2'd3 - pos[1:0];
    logical = STEP_PHASES[idx];
    drive = '0;
    for (int i = 0; i < 4; i++) drive[pin_map[i]] = logical[i];
    return drive;
  endfunction

  function automatic coil_beat_t step_stepper(shs_pkg::mode_t mode, logic [15:0] tgt,
                                              logic level);
    coil_beat_t r;
    logic [3:0] drive;
    drive = '0;
    case (mode)
      shs_pkg::MODE_SET: begin
        goal_pos = tgt;
        homing_count = '0;
      end
      shs_pkg::MODE_STEP: begin
        if (goal_pos != cur_pos) begin
          cur_pos = cur_pos + 16'd1;
          steps_since_home = steps_since_home + 16'd1;
          sense_hall(level);
          drive = drive_pattern(cur_pos);
        end
      end
      shs_pkg::MODE_POLL: sense_hall(level);
      default: ;
    endcase
    r.spare = 1'b0;
    r.coils = drive;
    r.at_target = (goal_pos == cur_pos);
    r.home = (goal_pos == '0) && hall_active;
    r.hall_seen = hall_active;
    r.position = cur_pos;
    r.rotation_steps = lap_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s at cycle %0d: got %h expected %h", what, cycle_count, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = coil_beat_t'(out_tdata);
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[15:0], 16'h0);
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat.coils !== want_beat.coils)
          report_mismatch("coils", 16'(got_beat.coils), 16'(want_beat.coils));
        if (got_beat.at_target !== want_beat.at_target)
          report_mismatch("at_target", 16'(got_beat.at_target), 16'(want_beat.at_target));
        if (got_beat.home !== want_beat.home)
          report_mismatch("home", 16'(got_beat.home), 16'(want_beat.home));
        if (got_beat.hall_seen !== want_beat.hall_seen)
          report_mismatch("hall_seen", 16'(got_beat.hall_seen), 16'(want_beat.hall_seen));
        if (got_beat.position !== want_beat.position)
          report_mismatch("position", got_beat.position, want_beat.position);
        if (got_beat.rotation_steps !== want_beat.rotation_steps)
          report_mismatch("rotation_steps", got_beat.rotation_steps, want_beat.rotation_steps);
        if (got_beat.spare !== 1'b0)
          report_mismatch("zero fill", 16'(got_beat.spare), 16'h0);
      end
    end
  end

  // receiver stall pattern, re-picks one of four characters each time stall_phase wraps
  always @(negedge clk) begin
    if (stall_phase == 0) stall_sel = $urandom_range(0, 3);
    stall_phase = (stall_phase + 1) % 200;
    case (stall_sel)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      2: out_tready <= (stall_phase % 3 != 0);
      default: out_tready <= (stall_phase % 7 > 1);
    endcase
  end

  task automatic send_command(shs_pkg::mode_t mode, logic [15:0] tgt, logic level);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {{(shs_pkg::IN_DATA_W - 17){1'b0}}, level, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_beats.push_back(step_stepper(mode, tgt, level));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic load_coil_config(logic fwd, logic [1:0] m0, logic [1:0] m1,
                                  logic [1:0] m2, logic [1:0] m3);
    logic [shs_pkg::CFG_INDEX_W-1:0] regs [5];
    logic [shs_pkg::CFG_DATA_W-1:0] vals [5];
    regs = '{shs_pkg::CFG_FORWARD, shs_pkg::CFG_MAP_FIRST, shs_pkg::CFG_MAP_SECOND,
             shs_pkg::CFG_MAP_THIRD, shs_pkg::CFG_MAP_FOURTH};
    vals = '{{1'b0, fwd}, m0, m1, m2, m3};
    wait_for_results();
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    dir_forward = fwd;
    pin_map[0] = m0;
    pin_map[1] = m1;
    pin_map[2] = m2;
    pin_map[3] = m3;
    @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_NONE, 16'hFFFF, 1'b0);
    send_command(shs_pkg::MODE_STEP, 16'hFFFF, 1'b0);
  endtask

  task automatic test_target_approach();
    send_command(shs_pkg::MODE_SET, 16'd3, 1'b0);
    repeat (4) send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
  endtask

  task automatic test_homing_limit();
    send_command(shs_pkg::MODE_SET, 16'd1000, 1'b1);
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b0);
    // magnet still there, not rearmed
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b0);
    send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b0);
    repeat (3) begin
      send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b1);
      send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b0);
    end
  endtask

  task automatic test_homing_below_target();
    send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_SET, 16'd2, 1'b1);
    repeat (2) send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_SET, 16'd1, 1'b1);
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b0);
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
  endtask

  task automatic run_phases();
    send_command(shs_pkg::MODE_SET, cur_pos + 16'd4, 1'b1);
    repeat (4) send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
  endtask

  task automatic test_coil_maps();
    load_coil_config(1'b0, 2'd0, 2'd1, 2'd2, 2'd3);
    run_phases();
    load_coil_config(1'b1, 2'd3, 2'd2, 2'd1, 2'd0);
    run_phases();
    load_coil_config(1'b0, 2'd3, 2'd3, 2'd3, 2'd3);
    run_phases();
    load_coil_config(1'b1, 2'd0, 2'd0, 2'd2, 2'd2);
    run_phases();
    load_coil_config(1'b1, 2'd0, 2'd1, 2'd2, 2'd3);
  endtask

  // long run toward a far target, then a homing rebases both
  task automatic test_long_travel();
    send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_SET, 16'hFFFF, 1'b1);
    repeat (200) send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b0);
    repeat (3) send_command(shs_pkg::MODE_STEP, 16'h0000, 1'b1);
    send_command(shs_pkg::MODE_POLL, 16'h0000, 1'b0);
  endtask

  task automatic random_command();
    int r;
    int pick;
    logic level;
    logic [15:0] tgt;
    r = $urandom_range(0, 99);
    if (magnet_left > 0) begin
      magnet_left--;
      level = 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      magnet_left = $urandom_range(0, 4);
      level = 1'b0;
    end else begin
      level = 1'b1;
    end
    if ($urandom_range(0, 29) == 0) level = ~level;
    tgt = 16'($urandom_range(0, 16'hFFFF));
    if (r < 8) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) tgt = cur_pos + 16'($urandom_range(0, 40));
      else if (pick == 7) tgt = cur_pos - 16'($urandom_range(1, 3));
      else if (pick == 8) tgt = 16'h0000;
      else if (pick == 9) tgt = 16'hFFFF;
      send_command(shs_pkg::MODE_SET, tgt, level);
    end else if (r < 80) begin
      send_command(shs_pkg::MODE_STEP, tgt, level);
    end else if (r < 95) begin
      send_command(shs_pkg::MODE_POLL, tgt, level);
    end else begin
      send_command(shs_pkg::MODE_NONE, tgt, level);
    end
  endtask

  task automatic test_random_traffic();
    repeat (200) random_command();
    load_coil_config(1'b0, 2'd3, 2'd2, 2'd1, 2'd0);
    repeat (200) random_command();
    load_coil_config(1'b0, 2'd0, 2'd0, 2'd0, 2'd0);
    repeat (200) random_command();
    load_coil_config(1'b1, 2'd3, 2'd3, 2'd3, 2'd3);
    repeat (150) random_command();
    // sender holds off until the pipe is empty
    wait_for_results();
    repeat (50) random_command();
    load_coil_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
    repeat (150) random_command();
  endtask

  initial begin
    reset_stepper();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_target_approach();
    test_homing_limit();
    test_homing_below_target();
    test_coil_maps();
    test_random_traffic();
    test_long_travel();
    wait_for_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/shs_pkg.sv
src/shs_coil_drive.sv
src/stepper_homing_sequencer.sv
tb/testbench.sv
